// ----- rtl/core/jpeg_marker_segment_walker_macros.svh -----
// Assertion macros shared by the checker file.
`ifndef JPEG_MARKER_SEGMENT_WALKER_MACROS_SVH
`define JPEG_MARKER_SEGMENT_WALKER_MACROS_SVH

// Check a property on every clock edge once reset is released.
`define JMSW_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a property on every clock edge, reset cycles included.
`define JMSW_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- rtl/core/jmsw_pkg.sv -----
package jmsw_pkg;

  localparam int unsigned FillLimitDef = 10;

  localparam logic [7:0] MarkPrefix = 8'hFF;
  localparam logic [7:0] CodeSoi    = 8'hD8;
  localparam logic [7:0] CodeSos    = 8'hDA;
  localparam logic [7:0] CodeEoi    = 8'hD9;

  typedef enum logic [2:0] {
    KIND_SEGMENT  = 3'd0,
    KIND_OK       = 3'd1,
    KIND_NOT_JPEG = 3'd2,
    KIND_FILL     = 3'd3,
    KIND_SHORT    = 3'd4,
    KIND_OVERRUN  = 3'd5,
    KIND_TRUNC    = 3'd6
  } result_kind_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    result_kind_t result_kind;
    logic [7:0]   marker_code;
    logic [15:0]  segment_length;
    logic [31:0]  payload_offset;
  } result_t;

  typedef struct packed {
    logic    valid;
    result_t res;
  } parse_out_t;

endpackage

// ----- rtl/core/jpeg_marker_segment_walker.sv -----
// JPEG marker segment walker: feed the file one byte per transfer, with
// in_first_byte set on offset 0 (this restarts the parser at any time) and
// in_last_byte on the final byte. The file must open with FF D8; after that
// each marker search may take up to FILL_LIMIT+1 bytes and ends on a non-FF
// byte that follows FF. The two-byte big-endian length is checked against 2
// and against the size written through cfg_we/cfg_wdata (write it only while
// the walker is idle), each good segment is reported with its code, length
// and payload offset, and its payload is skipped. SOS or EOI ends the parse
// with an ok report; errors and truncation end it too, and bytes without
// in_first_byte are then dropped until the next restart. A byte gives zero or
// one result. The walker takes one byte every cycle while out_stall is low;
// the input register, the combinational parse logic and the result register
// lie between input transfer and result, and out_stall holds both stages without losing a byte.
module jpeg_marker_segment_walker
  import jmsw_pkg::*;
#(
  parameter int unsigned FILL_LIMIT = FillLimitDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_first_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_result_kind,
  output logic [7:0]  out_marker_code,
  output logic [15:0] out_segment_length,
  output logic [31:0] out_payload_offset
);

  logic       advance;
  logic       item_valid;
  in_item_t   item;
  parse_out_t po;

  // Input register: take a byte whenever the stage below advances.
  jmsw_in_stage u_in_stage (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data_byte (in_data_byte),
    .in_first_byte(in_first_byte),
    .in_last_byte (in_last_byte),
    .advance      (advance),
    .item_valid   (item_valid),
    .item         (item)
  );

  // Parse state and per-byte decision logic.
  jmsw_parser #(
    .FILL_LIMIT(FILL_LIMIT)
  ) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .item_valid(item_valid),
    .item      (item),
    .advance   (advance),
    .po        (po)
  );

  // Result register: drop bytes with no report, hold a report under stall.
  jmsw_out_stage u_out_stage (
    .clk               (clk),
    .rst_n             (rst_n),
    .item_valid        (item_valid),
    .po                (po),
    .advance           (advance),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_result_kind   (out_result_kind),
    .out_marker_code   (out_marker_code),
    .out_segment_length(out_segment_length),
    .out_payload_offset(out_payload_offset)
  );

endmodule

// ----- rtl/core/jmsw_in_stage.sv -----
module jmsw_in_stage
  import jmsw_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_data_byte,
  input  logic       in_first_byte,
  input  logic       in_last_byte,
  input  logic       advance,
  output logic       item_valid,
  output in_item_t   item
);

  logic     valid_r;
  in_item_t item_r;

  // Hold the byte while the parser cannot move it on.
  assign in_stall   = valid_r && !advance;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (!in_stall) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item_r <= '{data_byte: in_data_byte, first_byte: in_first_byte,
                  last_byte: in_last_byte};
    end
  end

endmodule

// ----- rtl/core/jmsw_parser.sv -----
module jmsw_parser
  import jmsw_pkg::*;
#(
  parameter int unsigned FILL_LIMIT = FillLimitDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  input  logic        item_valid,
  input  in_item_t    item,
  input  logic        advance,
  output parse_out_t  po
);

  localparam int unsigned FillW = $clog2(FILL_LIMIT + 1);
  localparam logic [FillW-1:0] FillMax = FillW'(FILL_LIMIT);

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_SOI    = 3'd1,
    PH_SEARCH = 3'd2,
    PH_LEN_HI = 3'd3,
    PH_LEN_LO = 3'd4,
    PH_SKIP   = 3'd5
  } phase_t;

  phase_t           phase_r,  phase_nxt;
  logic [31:0]      pos_r,    pos_nxt;
  logic [FillW-1:0] fill_r,   fill_nxt;
  logic [7:0]       prev_r,   prev_nxt;
  logic [7:0]       marker_r, marker_nxt;
  logic [7:0]       len_hi_r, len_hi_nxt;
  logic [15:0]      skip_r,   skip_nxt;
  logic [31:0]      file_len_r;

  logic [15:0] seg_len;
  logic [32:0] seg_end;

  assign seg_len = {len_hi_r, item.data_byte};
  // Offset just past the segment's last byte, compared without wrap against the file size.
  assign seg_end = {1'b0, pos_r} + 33'(seg_len) - 33'd1;

  always_comb begin
    phase_nxt  = phase_r;
    pos_nxt    = pos_r;
    fill_nxt   = fill_r;
    prev_nxt   = prev_r;
    marker_nxt = marker_r;
    len_hi_nxt = len_hi_r;
    skip_nxt   = skip_r;
    po         = '0;

    if (item.first_byte) begin
      pos_nxt   = 32'd1;
      phase_nxt = PH_SOI;
      if (item.data_byte != MarkPrefix) begin
        po.valid           = 1'b1;
        po.res.result_kind = KIND_NOT_JPEG;
        phase_nxt          = PH_IDLE;
      end
    end else if (phase_r != PH_IDLE) begin
      pos_nxt = pos_r + 32'd1;
      case (phase_r)
        PH_SOI: begin
          if (item.data_byte == CodeSoi) begin
            phase_nxt = PH_SEARCH;
            fill_nxt  = '0;
            prev_nxt  = '0;
          end else begin
            po.valid           = 1'b1;
            po.res.result_kind = KIND_NOT_JPEG;
            phase_nxt          = PH_IDLE;
          end
        end
        PH_SEARCH: begin
          if (item.data_byte != MarkPrefix && prev_r == MarkPrefix) begin
            marker_nxt = item.data_byte;
            phase_nxt  = PH_LEN_HI;
          end else if (fill_r >= FillMax) begin
            po.valid           = 1'b1;
            po.res.result_kind = KIND_FILL;
            phase_nxt          = PH_IDLE;
          end else begin
            prev_nxt = item.data_byte;
            fill_nxt = fill_r + FillW'(1);
          end
        end
        PH_LEN_HI: begin
          len_hi_nxt = item.data_byte;
          phase_nxt  = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          po.valid              = 1'b1;
          po.res.marker_code    = marker_r;
          po.res.segment_length = seg_len;
          po.res.payload_offset = pos_r + 32'd1;
          phase_nxt             = PH_IDLE;
          if (seg_len < 16'd2) begin
            po.res.result_kind = KIND_SHORT;
          end else if (seg_end > {1'b0, file_len_r}) begin
            po.res.result_kind = KIND_OVERRUN;
          end else if (marker_r == CodeSos || marker_r == CodeEoi) begin
            po.res.result_kind = KIND_OK;
          end else begin
            po.res.result_kind = KIND_SEGMENT;
            if (seg_len == 16'd2) begin
              phase_nxt = PH_SEARCH;
              fill_nxt  = '0;
              prev_nxt  = '0;
            end else begin
              skip_nxt  = seg_len - 16'd2;
              phase_nxt = PH_SKIP;
            end
          end
        end
        PH_SKIP: begin
          skip_nxt = skip_r - 16'd1;
          if (skip_nxt == 16'd0) begin
            phase_nxt = PH_SEARCH;
            fill_nxt  = '0;
            prev_nxt  = '0;
          end
        end
        default: begin
          phase_nxt = PH_IDLE;
        end
      endcase
    end

    // An unfinished parse on the last byte overrides any report.
    if (item.last_byte && phase_nxt != PH_IDLE) begin
      po.valid = 1'b1;
      po.res   = '{result_kind: KIND_TRUNC, default: '0};
      phase_nxt = PH_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      pos_r      <= '0;
      fill_r     <= '0;
      prev_r     <= '0;
      marker_r   <= '0;
      len_hi_r   <= '0;
      skip_r     <= '0;
      file_len_r <= '0;
    end else begin
      if (cfg_we) begin
        file_len_r <= cfg_wdata;
      end
      if (item_valid && advance) begin
        phase_r  <= phase_nxt;
        pos_r    <= pos_nxt;
        fill_r   <= fill_nxt;
        prev_r   <= prev_nxt;
        marker_r <= marker_nxt;
        len_hi_r <= len_hi_nxt;
        skip_r   <= skip_nxt;
      end
    end
  end

endmodule

// ----- rtl/core/jmsw_out_stage.sv -----
module jmsw_out_stage
  import jmsw_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        item_valid,
  input  parse_out_t  po,
  output logic        advance,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_result_kind,
  output logic [7:0]  out_marker_code,
  output logic [15:0] out_segment_length,
  output logic [31:0] out_payload_offset
);

  logic    valid_r;
  result_t res_r;

  // Move on whenever the result register is empty or being drained.
  assign advance            = !valid_r || !out_stall;
  assign out_valid          = valid_r;
  assign out_result_kind    = res_r.result_kind;
  assign out_marker_code    = res_r.marker_code;
  assign out_segment_length = res_r.segment_length;
  assign out_payload_offset = res_r.payload_offset;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (advance) begin
      valid_r <= item_valid && po.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && item_valid && po.valid) begin
      res_r <= po.res;
    end
  end

endmodule

// ----- rtl/core/jmsw_checker.sv -----
`include "jpeg_marker_segment_walker_macros.svh"

module jmsw_checker
  import jmsw_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [2:0]  out_result_kind,
  input logic [7:0]  out_marker_code,
  input logic [15:0] out_segment_length,
  input logic [31:0] out_payload_offset
);

  `JMSW_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_valid, "result after reset")

  `JMSW_ASSERT(a_stall_hold, clk, rst_n,
    out_valid && out_stall |=> out_valid && $stable(out_result_kind) &&
      $stable(out_marker_code) && $stable(out_segment_length) &&
      $stable(out_payload_offset),
    "stalled result changed")

  `JMSW_ASSERT(a_plain_err_zero, clk, rst_n,
    out_valid && (out_result_kind == KIND_NOT_JPEG || out_result_kind == KIND_FILL ||
      out_result_kind == KIND_TRUNC) |-> out_marker_code == 8'd0 &&
      out_segment_length == 16'd0 && out_payload_offset == 32'd0,
    "error report carries fields")

  `JMSW_ASSERT(a_good_len, clk, rst_n,
    out_valid && (out_result_kind == KIND_SEGMENT || out_result_kind == KIND_OK ||
      out_result_kind == KIND_OVERRUN) |-> out_segment_length >= 16'd2,
    "accepted segment shorter than two")

  `JMSW_ASSERT(a_short_len, clk, rst_n,
    out_valid && out_result_kind == KIND_SHORT |-> out_segment_length < 16'd2,
    "short report with valid length")

endmodule

bind jpeg_marker_segment_walker jmsw_checker u_jmsw_checker (.*);
